[rtl/core/pcae_pkg.sv]
// pcae_pkg: shared sizes, codes and helpers of the pending command abort engine
// no dependencies; used by the interfaces, the top level and the checker
`default_nettype none

package pcae_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IO_QUEUES   = 8;
    localparam int STORE_DEPTH = (IO_QUEUES + 1) * QUEUE_DEPTH;
    localparam int MAX_RESULTS = 63;

    localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
    localparam int CAP_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int QID_W    = 4;
    localparam int CID_W    = 16;
    localparam int STATUS_W = 16;
    localparam int CNT_W    = 6;
    localparam int ADDR_W   = $clog2(STORE_DEPTH);

    localparam logic [7:0] STATUS_CODE_INTERNAL = 8'h06;
    localparam logic [6:0] STATUS_TYPE_GENERIC  = 7'h00;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_ABORT = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        KIND_ABORT = 2'd0,
        KIND_NONE  = 2'd1,
        KIND_BAD   = 2'd2
    } kind_t;

    function automatic logic [STATUS_W-1:0] make_status(input logic phase);
        logic [STATUS_W-1:0] s;
        begin
            s = {STATUS_TYPE_GENERIC, STATUS_CODE_INTERNAL, phase};
            return s;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/pcae_if.sv]
// pcae_if: valid/ready channels of the pending command abort engine
// depends on pcae_pkg for field widths
`default_nettype none

interface pcae_in_if;
    import pcae_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [QID_W-1:0]      queue_id;
    logic [SLOT_W-1:0]     slot;
    logic [CID_W-1:0]      cid;
    logic [SLOT_W-1:0]     sq_head;
    logic [SLOT_W-1:0]     sq_tail;
    logic [CAP_W-1:0]      sq_capacity;
    logic [SLOT_W-1:0]     cq_tail;
    logic [CAP_W-1:0]      cq_capacity;
    logic                  phase_in;
    logic                  queue_enabled;

    modport source
    (
        output valid, command, queue_id, slot, cid, sq_head, sq_tail, sq_capacity,
               cq_tail, cq_capacity, phase_in, queue_enabled,
        input  ready
    );

    modport sink
    (
        input  valid, command, queue_id, slot, cid, sq_head, sq_tail, sq_capacity,
               cq_tail, cq_capacity, phase_in, queue_enabled,
        output ready
    );
endinterface

interface pcae_out_if;
    import pcae_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [SLOT_W-1:0]     cq_slot;
    logic [SLOT_W-1:0]     sq_head_echo;
    logic [QID_W-1:0]      sq_id;
    logic [CID_W-1:0]      cid_out;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     new_sq_head;
    logic [SLOT_W-1:0]     new_cq_tail;
    logic                  new_phase;
    logic [CNT_W-1:0]      aborted_count;
    logic                  last;

    modport source
    (
        output valid, kind, cq_slot, sq_head_echo, sq_id, cid_out, status, new_sq_head,
               new_cq_tail, new_phase, aborted_count, last,
        input  ready
    );

    modport sink
    (
        input  valid, kind, cq_slot, sq_head_echo, sq_id, cid_out, status, new_sq_head,
               new_cq_tail, new_phase, aborted_count, last,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/pending_command_abort_engine.sv]
// pending_command_abort_engine: command id store and queue abort sequencer
// depends on pcae_pkg and the channel interfaces in pcae_if.sv
//
//   channel   | dir | handshake     | carries
//   ----------+-----+---------------+---------------------------------------
//   in_ch     | in  | valid/ready   | load (slot, cid) or abort descriptor
//   out_ch    | out | valid/ready   | one completion or status per transfer
//   cfg       | in  | cfg_we        | io_queue_count
//
// a load is written to the store at accept. an abort passes through accept,
// descriptor check and store read, then gives one completion per cycle while
// out_ch is not stalled; a single status result is issued from the check.
// the single store read port and its registered data set that pace.
// the store has no reset; control state clears asynchronously on rst_n.
// a stall on out_ch holds the walk; a finished result waits in the output
// register while the next item is accepted.
`default_nettype none

module pending_command_abort_engine
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [pcae_pkg::QID_W-1:0] cfg_wdata,
    pcae_in_if.sink                         in_ch,
    pcae_out_if.source                      out_ch
);
    import pcae_pkg::*;

    typedef enum logic [3:0]
    {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_READ  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [QID_W-1:0]    ioq_reg;
    logic [QID_W-1:0]    qid_reg;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [SLOT_W-1:0]   tail_reg;
    logic [CAP_W-1:0]    sqcap_reg;
    logic [SLOT_W-1:0]   cqt_reg, cqt_next;
    logic [CAP_W-1:0]    cqcap_reg;
    logic                phase_reg, phase_next;
    logic                en_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [31:0]         total_reg, total_next;
    logic [CID_W-1:0]    rd_data_reg;

    logic                out_valid_reg, out_valid_next;
    kind_t               kind_reg;
    logic [SLOT_W-1:0]   cq_slot_reg;
    logic [SLOT_W-1:0]   head_echo_reg;
    logic [QID_W-1:0]    sq_id_reg;
    logic [CID_W-1:0]    cid_out_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   new_head_reg;
    logic [SLOT_W-1:0]   new_tail_reg;
    logic                new_phase_reg;
    logic [CNT_W-1:0]    count_out_reg;
    logic                last_reg;

    logic [CID_W-1:0]    store_mem [STORE_DEPTH];

    logic                in_fire;
    logic                out_free;
    logic                load_out;
    logic                load_err;
    logic [QID_W-1:0]    qcount;
    logic [CAP_W-1:0]    cqcap_eff;
    logic [CAP_W-1:0]    head_inc;
    logic [CAP_W-1:0]    cqt_inc;
    logic [SLOT_W-1:0]   head_wrap;
    logic [SLOT_W-1:0]   cqt_wrap;
    logic                phase_wrap;
    logic [CNT_W-1:0]    count_inc;
    logic                is_last;
    logic                chk_err;
    kind_t               chk_kind;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    assign qcount    = (ioq_reg > QID_W'(IO_QUEUES)) ? QID_W'(IO_QUEUES) : ioq_reg;
    assign cqcap_eff = (qid_reg == '0) ? sqcap_reg : cqcap_reg;

    // ring advance, wraps at the capacity
    assign head_inc   = {1'b0, head_reg} + CAP_W'(1);
    assign cqt_inc    = {1'b0, cqt_reg} + CAP_W'(1);
    assign head_wrap  = (head_inc == sqcap_reg) ? '0 : head_inc[SLOT_W-1:0];
    assign cqt_wrap   = (cqt_inc == cqcap_eff) ? '0 : cqt_inc[SLOT_W-1:0];
    assign phase_wrap = phase_reg ^ (cqt_wrap == '0);
    assign count_inc  = count_reg + CNT_W'(1);
    assign is_last    = (head_wrap == tail_reg) || (count_reg == CNT_W'(MAX_RESULTS - 1));

    always_comb
    begin
        chk_err  = 1'b1;
        chk_kind = KIND_BAD;
        if (qid_reg > qcount)
        begin
            chk_kind = KIND_BAD;
        end
        else if ((qid_reg != '0) && !en_reg)
        begin
            chk_kind = KIND_NONE;
        end
        else if ((head_reg == tail_reg) || (sqcap_reg == '0))
        begin
            chk_kind = KIND_NONE;
        end
        else if ((sqcap_reg > CAP_W'(QUEUE_DEPTH)) || ({1'b0, head_reg} >= sqcap_reg) ||
                 ({1'b0, tail_reg} >= sqcap_reg) || (cqcap_eff == '0) ||
                 (cqcap_eff > CAP_W'(QUEUE_DEPTH)) || ({1'b0, cqt_reg} >= cqcap_eff))
        begin
            chk_kind = KIND_BAD;
        end
        else
        begin
            chk_err = 1'b0;
        end
    end

    // store ports: loads write at accept, the walk reads one slot ahead
    assign wr_en   = in_fire && (in_ch.command == CMD_LOAD) &&
                     (in_ch.queue_id <= QID_W'(IO_QUEUES));
    assign wr_addr = ADDR_W'({in_ch.queue_id, in_ch.slot});
    assign load_out = (state_reg == ST_EMIT) && out_free;
    assign load_err = (state_reg == ST_CHECK) && chk_err && out_free;
    assign rd_en    = (state_reg == ST_READ) || (load_out && !is_last);
    assign rd_addr  = (state_reg == ST_READ) ? ADDR_W'({qid_reg, head_reg})
                                             : ADDR_W'({qid_reg, head_wrap});

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= in_ch.cid;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        cqt_next       = cqt_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_ch.command == CMD_ABORT))
                begin
                    state_next = ST_CHECK;
                    head_next  = in_ch.sq_head;
                    cqt_next   = in_ch.cq_tail;
                    phase_next = in_ch.phase_in;
                    count_next = '0;
                end
            end
            ST_CHECK:
            begin
                if (!chk_err)
                begin
                    state_next = ST_READ;
                end
                else if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    head_next      = head_wrap;
                    cqt_next       = cqt_wrap;
                    phase_next     = phase_wrap;
                    count_next     = count_inc;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                        total_next = total_reg + 32'(count_inc);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ioq_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                ioq_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg   <= head_next;
        cqt_reg    <= cqt_next;
        phase_reg  <= phase_next;
        count_reg  <= count_next;
        if (in_fire)
        begin
            qid_reg   <= in_ch.queue_id;
            tail_reg  <= in_ch.sq_tail;
            sqcap_reg <= in_ch.sq_capacity;
            cqcap_reg <= in_ch.cq_capacity;
            en_reg    <= in_ch.queue_enabled;
        end
        if (load_out)
        begin
            kind_reg      <= KIND_ABORT;
            cq_slot_reg   <= cqt_reg;
            head_echo_reg <= head_reg;
            sq_id_reg     <= qid_reg;
            cid_out_reg   <= rd_data_reg;
            status_reg    <= make_status(phase_reg);
            new_head_reg  <= is_last ? head_wrap : '0;
            new_tail_reg  <= is_last ? cqt_wrap : '0;
            new_phase_reg <= is_last ? phase_wrap : 1'b0;
            count_out_reg <= is_last ? count_inc : '0;
            last_reg      <= is_last;
        end
        else if (load_err)
        begin
            kind_reg      <= chk_kind;
            cq_slot_reg   <= '0;
            head_echo_reg <= '0;
            sq_id_reg     <= qid_reg;
            cid_out_reg   <= '0;
            status_reg    <= '0;
            new_head_reg  <= head_reg;
            new_tail_reg  <= cqt_reg;
            new_phase_reg <= phase_reg;
            count_out_reg <= '0;
            last_reg      <= 1'b1;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.kind          = kind_reg;
    assign out_ch.cq_slot       = cq_slot_reg;
    assign out_ch.sq_head_echo  = head_echo_reg;
    assign out_ch.sq_id         = sq_id_reg;
    assign out_ch.cid_out       = cid_out_reg;
    assign out_ch.status        = status_reg;
    assign out_ch.new_sq_head   = new_head_reg;
    assign out_ch.new_cq_tail   = new_tail_reg;
    assign out_ch.new_phase     = new_phase_reg;
    assign out_ch.aborted_count = count_out_reg;
    assign out_ch.last          = last_reg;

endmodule

`default_nettype wire

[rtl/core/pcae_checker.sv]
// pcae_checker: port-level assertions for the pending command abort engine
// depends on pcae_pkg; bound to pending_command_abort_engine below
`default_nettype none

module pcae_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [1:0]                    out_kind,
    input wire logic [pcae_pkg::CID_W-1:0]    out_cid,
    input wire logic [pcae_pkg::STATUS_W-1:0] out_status,
    input wire logic [pcae_pkg::CNT_W-1:0]    out_count,
    input wire logic                          out_last
);
    import pcae_pkg::*;

    // a stalled transfer keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_cid) && $stable(out_last))
        else $error("output changed while stalled");

    // status and reject results stand alone
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind != KIND_ABORT) |-> out_last && (out_count == '0))
        else $error("reject result not single");

    a_mid_is_abort: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> (out_kind == KIND_ABORT) && (out_count == '0))
        else $error("non-final result malformed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_ABORT) |->
        (out_status[STATUS_W-1:1] == {STATUS_TYPE_GENERIC, STATUS_CODE_INTERNAL}))
        else $error("abort completion status wrong");

    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last && (out_kind == KIND_ABORT) |-> (out_count != '0))
        else $error("final completion with zero count");

endmodule

bind pending_command_abort_engine pcae_checker u_pcae_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_kind   (out_ch.kind),
    .out_cid    (out_ch.cid_out),
    .out_status (out_ch.status),
    .out_count  (out_ch.aborted_count),
    .out_last   (out_ch.last)
);

`default_nettype wire
